/* rtl/rhh_pkg.sv */
// Package for the Robin Hood hash table: shared constants, types and codes.
// Used by every module of the block; depends on nothing else.
package rhh_pkg;

  localparam int unsigned TableSizeDefault = 1024;
  localparam logic [6:0]  FillReset        = 7'd85;
  localparam logic [6:0]  PercentAll       = 7'd100;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_ERASE  = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_FOUND  = 2'd0,
    ST_INSERT = 2'd1,
    ST_ABSENT = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FRD,
    S_FCHK,
    S_IRD,
    S_ICHK,
    S_ERD,
    S_ECHK,
    S_CLR,
    S_DONE
  } state_e;

  // One slot's payload as it is stored.
  typedef struct packed {
    logic [63:0] key;
    logic [63:0] hash;
    logic [31:0] value;
    logic [3:0]  len;
  } slot_t;

  // Masks the key down to its significant bytes.
  function automatic logic [63:0] key_mask(input logic [3:0] len);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (len > 4'(b)) m[b*8 +: 8] = 8'hFF;
    end
    return m;
  endfunction

endpackage

/* rtl/robin_hood_hash_table.sv */
// Top level of the Robin Hood hash table: sequencer, count and config.
// Depends on rhh_pkg and rhh_mem.
//
//  channel  | signals                                        | direction
//  request  | start_i, busy_o, action_i, key_i, key_bytes_i, | in
//           | hash_i, value_i                                |
//  result   | done_o, status_o, result_value_o               | out
//  config   | cfg_valid_i, cfg_ready_o, cfg_data_i           | in
//
// After reset a clearing pass empties every slot of the table; busy_o
// stays high meanwhile. Each probed slot takes a read state and then a
// check state, as the slot memory reads synchronously. A lookup raises
// done_o from the done state after its last probe and drops busy_o in the
// cycle after; an insert or an erase may first walk more slots, reading each
// and writing back. The result strobe done_o lasts one cycle and cannot be
// stalled. Configuration is taken only while idle and no item is offered.
module robin_hood_hash_table #(
  parameter int unsigned TableSize = rhh_pkg::TableSizeDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  action_i,
  input  logic [63:0] key_i,
  input  logic [3:0]  key_bytes_i,
  input  logic [63:0] hash_i,
  input  logic [31:0] value_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [31:0] result_value_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i
);

  localparam int unsigned Aw = $clog2(TableSize);
  localparam int unsigned Dw = $clog2(TableSize + 1);
  localparam int unsigned Cw = $clog2(TableSize + 1);
  localparam int unsigned Pw = Cw + 7;
  localparam logic [Aw-1:0] LastSlot = Aw'(TableSize - 1);

  rhh_pkg::state_e state_q, state_d;
  logic [6:0]      fill_q;
  logic [Cw-1:0]   count_q, count_d;
  logic [Pw-1:0]   lhs_q, rhs_q;
  logic [Aw-1:0]   idx_q, idx_d;
  logic [Aw-1:0]   home_q;
  logic [Dw-1:0]   dist_q, dist_d;
  rhh_pkg::slot_t  req_q, car_q, car_d;
  logic [1:0]      act_q;
  logic [31:0]     rv_q, rv_d;
  logic [1:0]      st_q, st_d;

  logic            rd_en, wr_en, wr_valid;
  logic [Aw-1:0]   rd_addr, wr_addr, nxt_idx;
  rhh_pkg::slot_t  rd_slot, wr_slot;
  logic            rd_valid;
  logic [Dw-1:0]   rd_dist, wr_dist;
  logic            hit, full;
  logic [6:0]      pct;

  rhh_mem #(.TableSize(TableSize)) u_mem (
    .clk_i, .rd_en_i(rd_en), .rd_addr_i(rd_addr), .rd_slot_o(rd_slot),
    .rd_valid_o(rd_valid), .rd_dist_o(rd_dist), .wr_en_i(wr_en),
    .wr_addr_i(wr_addr), .wr_slot_i(wr_slot), .wr_valid_i(wr_valid),
    .wr_dist_i(wr_dist)
  );

  assign cfg_ready_o = (state_q == rhh_pkg::S_IDLE) && !start_i;
  assign busy_o      = (state_q != rhh_pkg::S_IDLE);
  assign nxt_idx     = (idx_q == LastSlot) ? '0 : idx_q + 1'b1;
  assign hit = rd_valid && (rd_slot.hash == req_q.hash) && (rd_slot.len == req_q.len)
               && (rd_slot.key == req_q.key);
  assign pct  = (fill_q > rhh_pkg::PercentAll) ? rhh_pkg::PercentAll : fill_q;
  assign full = (lhs_q >= rhs_q);

  // Fill limit register and the two products of the full check.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= rhh_pkg::FillReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      fill_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lhs_q <= Pw'(count_q) * Pw'(rhh_pkg::PercentAll);
    rhs_q <= Pw'(TableSize) * Pw'(pct);
  end

  // Request capture. The home slot is the low hash bits.
  always_ff @(posedge clk_i) begin
    if (state_q == rhh_pkg::S_IDLE && start_i) begin
      req_q.key   <= key_i & rhh_pkg::key_mask(key_bytes_i);
      req_q.hash  <= hash_i;
      req_q.value <= value_i;
      req_q.len   <= key_bytes_i;
      act_q       <= action_i;
      home_q      <= hash_i[Aw-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rhh_pkg::S_CLR;
      count_q <= '0;
      idx_q   <= '0;
      dist_q  <= '0;
      st_q    <= '0;
      rv_q    <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      dist_q  <= dist_d;
      st_q    <= st_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    car_q <= car_d;
  end

  // Sequencer: clearing pass after reset, then find, then insert walk or backward shift.
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    idx_d    = idx_q;
    dist_d   = dist_q;
    car_d    = car_q;
    st_d     = st_q;
    rv_d     = rv_q;
    rd_en    = 1'b0;
    rd_addr  = idx_q;
    wr_en    = 1'b0;
    wr_addr  = idx_q;
    wr_slot  = car_q;
    wr_valid = 1'b1;
    wr_dist  = dist_q;
    done_o   = 1'b0;
    unique case (state_q)
      rhh_pkg::S_CLR: begin
        wr_en    = 1'b1;
        wr_valid = 1'b0;
        idx_d    = nxt_idx;
        if (idx_q == LastSlot) state_d = rhh_pkg::S_IDLE;
      end
      rhh_pkg::S_IDLE: begin
        if (start_i) begin
          if (action_i == rhh_pkg::ACT_NONE) begin
            st_d = rhh_pkg::ST_ABSENT; rv_d = '0; state_d = rhh_pkg::S_DONE;
          end else begin
            idx_d  = hash_i[Aw-1:0];
            dist_d = '0;
            state_d = rhh_pkg::S_FRD;
          end
        end
      end
      rhh_pkg::S_FRD: begin
        rd_en = 1'b1;
        state_d = rhh_pkg::S_FCHK;
      end
      rhh_pkg::S_FCHK: begin
        if (!rd_valid || dist_q > rd_dist || dist_q == Dw'(TableSize)) begin
          // Key absent.
          st_d = rhh_pkg::ST_ABSENT; rv_d = '0; state_d = rhh_pkg::S_DONE;
          if (act_q == rhh_pkg::ACT_INSERT) begin
            if (full) begin
              st_d = rhh_pkg::ST_FULL;
            end else begin
              st_d = rhh_pkg::ST_INSERT; rv_d = req_q.value;
              car_d = req_q; idx_d = home_q; dist_d = '0;
              state_d = rhh_pkg::S_IRD;
            end
          end
        end else if (hit) begin
          st_d = rhh_pkg::ST_FOUND; rv_d = rd_slot.value; state_d = rhh_pkg::S_DONE;
          if (act_q == rhh_pkg::ACT_ERASE) begin
            count_d = count_q - 1'b1;
            idx_d   = idx_q;
            state_d = rhh_pkg::S_ERD;
          end
        end else begin
          idx_d = nxt_idx; dist_d = dist_q + 1'b1; state_d = rhh_pkg::S_FRD;
        end
      end
      rhh_pkg::S_IRD: begin
        rd_en = 1'b1;
        state_d = rhh_pkg::S_ICHK;
      end
      rhh_pkg::S_ICHK: begin
        if (!rd_valid) begin
          wr_en = 1'b1; count_d = count_q + 1'b1; state_d = rhh_pkg::S_DONE;
        end else begin
          dist_d = dist_q + 1'b1;
          if (dist_q > rd_dist) begin
            wr_en  = 1'b1;
            car_d  = rd_slot;
            dist_d = rd_dist + 1'b1;
          end
          idx_d = nxt_idx; state_d = rhh_pkg::S_IRD;
        end
      end
      rhh_pkg::S_ERD: begin
        // Read the follower of the hole at idx_q.
        rd_en = 1'b1; rd_addr = nxt_idx;
        state_d = rhh_pkg::S_ECHK;
      end
      rhh_pkg::S_ECHK: begin
        wr_en = 1'b1;
        if (!rd_valid || rd_dist == '0) begin
          wr_valid = 1'b0; wr_slot = rd_slot; wr_dist = '0;
          state_d = rhh_pkg::S_DONE;
        end else begin
          wr_slot = rd_slot; wr_dist = rd_dist - 1'b1;
          idx_d = nxt_idx; state_d = rhh_pkg::S_ERD;
        end
      end
      rhh_pkg::S_DONE: begin
        done_o = 1'b1; state_d = rhh_pkg::S_IDLE;
      end
      default: state_d = rhh_pkg::S_IDLE;
    endcase
  end

  assign status_o       = st_q;
  assign result_value_o = rv_q;

`ifndef NO_ASSERTIONS
  // A result strobe is never followed directly by another.
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("double result strobe");
  // Count never exceeds the table size.
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Cw'(TableSize)) else $error("item count overflow");
  // Full refusals only when insert was requested.
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == rhh_pkg::ST_FULL) |-> act_q == rhh_pkg::ACT_INSERT)
    else $error("full status on non-insert");
  // The home slot is taken from the low hash bits, so the size is a power of two.
  a_size: assert property (@(posedge clk_i)
    (TableSize & (TableSize - 1)) == 0) else $error("table size not a power of two");
`endif

endmodule

/* rtl/rhh_mem.sv */
// Slot storage: payload memory and metadata (valid, distance) memory.
// Depends on rhh_pkg. Meta has no reset value; the top's clearing pass empties it.
module rhh_mem #(
  parameter int unsigned TableSize = rhh_pkg::TableSizeDefault,
  localparam int unsigned Aw = $clog2(TableSize),
  localparam int unsigned Dw = $clog2(TableSize + 1)
) (
  input  logic                clk_i,
  input  logic                rd_en_i,
  input  logic [Aw-1:0]       rd_addr_i,
  output rhh_pkg::slot_t      rd_slot_o,
  output logic                rd_valid_o,
  output logic [Dw-1:0]       rd_dist_o,
  input  logic                wr_en_i,
  input  logic [Aw-1:0]       wr_addr_i,
  input  rhh_pkg::slot_t      wr_slot_i,
  input  logic                wr_valid_i,
  input  logic [Dw-1:0]       wr_dist_i
);

  rhh_pkg::slot_t       slot_mem [TableSize];
  logic [Dw:0]          meta_mem [TableSize];
  logic [Dw:0]          meta_rd;

  // Synchronous read and write, one port each.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      slot_mem[wr_addr_i] <= wr_slot_i;
      meta_mem[wr_addr_i] <= {wr_dist_i, wr_valid_i};
    end
    if (rd_en_i) begin
      rd_slot_o <= slot_mem[rd_addr_i];
      meta_rd   <= meta_mem[rd_addr_i];
    end
  end

  assign rd_valid_o = meta_rd[0];
  assign rd_dist_o  = meta_rd[Dw:1];

endmodule

/* dv/rhh_checker.sv */
// Checker for the Robin Hood hash table: watches the request, result and
// config channels, keeps its own copy of the table and compares every result.
// Depends on rhh_pkg for the action and status codes and the reset fill limit.
module rhh_checker #(
  parameter int unsigned Slots = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  action_i,
  input  logic [63:0] key_i,
  input  logic [3:0]  key_bytes_i,
  input  logic [63:0] hash_i,
  input  logic [31:0] value_i,
  input  logic        done_i,
  input  logic [1:0]  status_i,
  input  logic [31:0] result_value_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [6:0]  cfg_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o,
  output int          refused_o
);

  typedef struct packed {
    rhh_pkg::status_e status;
    logic [31:0]      value;
  } answer_t;

  // Shadow copy of the table.
  logic        occ_q   [Slots];
  logic [3:0]  len_q   [Slots];
  int unsigned dist_q  [Slots];
  logic [63:0] key_q   [Slots];
  logic [63:0] hash_q  [Slots];
  logic [31:0] val_q   [Slots];
  int unsigned entries_q;
  logic [6:0]  fill_pct_q;
  answer_t     answers_q[$];

  function automatic int unsigned wrap_next(int unsigned i);
    return (i + 1 >= Slots) ? 0 : i + 1;
  endfunction

  // Keeps only the significant key bytes.
  function automatic logic [63:0] sig_bytes(logic [63:0] k, logic [3:0] n);
    logic [63:0] m;
    m = (n >= 8) ? '1 : ((64'd1 << (n * 8)) - 64'd1);
    return k & m;
  endfunction

  // Probes from the home slot; returns the matching slot or -1.
  function automatic int locate(logic [63:0] k, logic [3:0] n, logic [63:0] h);
    int unsigned idx;
    idx = h % Slots;
    for (int unsigned p = 0; p < Slots; p++) begin
      if (!occ_q[idx] || p > dist_q[idx]) return -1;
      if (hash_q[idx] == h && len_q[idx] == n && key_q[idx] == k) return idx;
      idx = wrap_next(idx);
    end
    return -1;
  endfunction

  // Applies one request to the shadow table and returns its answer.
  function automatic answer_t apply_request(rhh_pkg::action_e act, logic [63:0] k_raw,
                                            logic [3:0] n, logic [63:0] h,
                                            logic [31:0] v);
    answer_t     ans;
    logic [63:0] k, ck, ch, tk, th;
    logic [31:0] cv, tv;
    logic [3:0]  cl, tl;
    int unsigned cd, td, idx, nx, pct;
    int          pos;
    ans.status = rhh_pkg::ST_ABSENT;
    ans.value  = '0;
    k = sig_bytes(k_raw, n);
    if (act == rhh_pkg::ACT_NONE) return ans;
    pos = locate(k, n, h);
    if (pos >= 0 && act != rhh_pkg::ACT_ERASE) begin
      ans.status = rhh_pkg::ST_FOUND;
      ans.value  = val_q[pos];
    end else if (act == rhh_pkg::ACT_INSERT) begin
      pct = (fill_pct_q > 100) ? 100 : fill_pct_q;
      if (entries_q * 100 >= Slots * pct) begin
        ans.status = rhh_pkg::ST_FULL;
      end else begin
        ck = k; ch = h; cv = v; cl = n; cd = 0;
        idx = h % Slots;
        for (int unsigned p = 0; p < Slots; p++) begin
          if (!occ_q[idx]) begin
            occ_q[idx] = 1'b1; key_q[idx] = ck; hash_q[idx] = ch;
            val_q[idx] = cv; len_q[idx] = cl; dist_q[idx] = cd;
            entries_q++;
            break;
          end
          // Richer resident gives up its slot to the carried entry.
          if (cd > dist_q[idx]) begin
            tk = key_q[idx]; th = hash_q[idx]; tv = val_q[idx];
            tl = len_q[idx]; td = dist_q[idx];
            key_q[idx] = ck; hash_q[idx] = ch; val_q[idx] = cv;
            len_q[idx] = cl; dist_q[idx] = cd;
            ck = tk; ch = th; cv = tv; cl = tl; cd = td;
          end
          cd++;
          idx = wrap_next(idx);
        end
        ans.status = rhh_pkg::ST_INSERT;
        ans.value  = v;
      end
    end else if (act == rhh_pkg::ACT_ERASE && pos >= 0) begin
      ans.status = rhh_pkg::ST_FOUND;
      ans.value  = val_q[pos];
      if (entries_q > 0) entries_q--;
      idx = pos;
      // Backward shift until an empty slot or an entry at its home.
      for (int unsigned p = 0; p < Slots; p++) begin
        nx = wrap_next(idx);
        if (!occ_q[nx] || dist_q[nx] == 0) break;
        key_q[idx] = key_q[nx]; hash_q[idx] = hash_q[nx];
        val_q[idx] = val_q[nx]; len_q[idx] = len_q[nx];
        dist_q[idx] = dist_q[nx] - 1;
        idx = nx;
      end
      occ_q[idx] = 1'b0;
    end
    return ans;
  endfunction

  // Results are checked first, then new items are predicted.
  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      for (int i = 0; i < Slots; i++) begin
        occ_q[i] = 1'b0;
        dist_q[i] = 0;
      end
      entries_q  = 0;
      fill_pct_q = rhh_pkg::FillReset;
      answers_q.delete();
      fail_count_o = 0;
      checked_o    = 0;
      refused_o    = 0;
    end else begin
      if (done_i) begin
        if (answers_q.size() == 0) begin
          $display("%0t: result with no item waiting: status %0d value %h",
                   $time, status_i, result_value_i);
          fail_count_o++;
        end else begin
          want = answers_q.pop_front();
          checked_o++;
          if (want.status == rhh_pkg::ST_FULL) refused_o++;
          if (status_i !== want.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, status_i);
            fail_count_o++;
          end
          if (result_value_i !== want.value) begin
            $display("%0t: result_value expected %h actual %h",
                     $time, want.value, result_value_i);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_i)
        answers_q.push_back(apply_request(rhh_pkg::action_e'(action_i), key_i,
                                          key_bytes_i, hash_i, value_i));
      if (cfg_valid_i && cfg_ready_i) fill_pct_q = cfg_data_i;
    end
    pending_o = answers_q.size();
  end

endmodule

/* dv/tb_top.sv */
// Testbench top for the Robin Hood hash table: clock, reset, stimulus and
// verdict. Depends on rhh_pkg, robin_hood_hash_table and rhh_checker.
module tb_top;

  localparam int PoolSize   = 64;
  localparam int CycleLimit = 3000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  action_i = rhh_pkg::ACT_LOOKUP;
  logic [63:0] key_i = '0;
  logic [3:0]  key_bytes_i = 4'd1;
  logic [63:0] hash_i = '0;
  logic [31:0] value_i = '0;
  logic        done_o;
  logic [1:0]  status_o;
  logic [31:0] result_value_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [6:0]  cfg_data_i = '0;

  int          fail_count, pending, checked, refused;
  int          cycles = 0;
  int          burst_left = 0;
  int          sent = 0;
  logic [63:0] pool_key  [PoolSize];
  logic [63:0] pool_hash [PoolSize];
  logic [3:0]  pool_len  [PoolSize];
  logic [6:0]  fill_steps[6] = '{7'd1, 7'd0, 7'd100, 7'd127, 7'd50, 7'd85};

  always #5 clk_i = ~clk_i;

  robin_hood_hash_table u_top (.*);

  rhh_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .action_i, .key_i, .key_bytes_i,
    .hash_i, .value_i, .done_i(done_o), .status_i(status_o),
    .result_value_i(result_value_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked),
    .refused_o(refused)
  );

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Offers one item and holds start_i until busy_o, sampled at the clock, is seen low.
  task automatic send_item(rhh_pkg::action_e act, logic [63:0] k, logic [3:0] n,
                           logic [63:0] h, logic [31:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                 : $urandom_range(1, 12);
    end
    action_i = act; key_i = k; key_bytes_i = n; hash_i = h; value_i = v;
    start_i = 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
    burst_left--;
    sent++;
  endtask

  // Writes the fill limit once every result is in.
  task automatic write_fill(logic [6:0] pct);
    start_i = 1'b0;
    while (pending != 0 || busy_o) @(negedge clk_i);
    cfg_data_i = pct;
    cfg_valid_i = 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Mostly pool keys so that hits, chains and erases happen often.
  task automatic random_item();
    int               r, p;
    rhh_pkg::action_e act;
    r = $urandom_range(0, 99);
    act = (r < 45) ? rhh_pkg::ACT_INSERT : (r < 70) ? rhh_pkg::ACT_LOOKUP :
          (r < 95) ? rhh_pkg::ACT_ERASE : rhh_pkg::ACT_NONE;
    p = $urandom_range(0, PoolSize - 1);
    if ($urandom_range(0, 9) == 0)
      send_item(act, rand64(), 4'($urandom_range(0, 15)), rand64(), $urandom);
    else
      send_item(act, pool_key[p], pool_len[p], pool_hash[p], $urandom);
  endtask

  initial begin
    // Clustered home slots, some near the table end to force wraparound.
    for (int i = 0; i < PoolSize; i++) begin
      pool_key[i] = rand64();
      pool_len[i] = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(0, 15))
                                                  : 4'($urandom_range(1, 8));
      pool_hash[i] = rand64();
      pool_hash[i][9:0] = (i % 8 == 7) ? 10'($urandom_range(1016, 1023))
                                       : 10'($urandom_range(0, 39));
      // Same hash and key with another length is a different key.
      if (i % 5 == 1) begin
        pool_hash[i] = pool_hash[i-1];
        pool_key[i]  = pool_key[i-1];
      end
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed items at the reset fill limit.
    send_item(rhh_pkg::ACT_INSERT, '1, 4'd8, '1, '1);
    send_item(rhh_pkg::ACT_LOOKUP, '1, 4'd8, '1, '0);
    send_item(rhh_pkg::ACT_INSERT, '1, 4'd8, '1, 32'h1234_5678);
    send_item(rhh_pkg::ACT_LOOKUP, '1, 4'd7, '1, '0);
    send_item(rhh_pkg::ACT_INSERT, '0, 4'd1, '0, '0);
    send_item(rhh_pkg::ACT_LOOKUP, 64'hFF00, 4'd1, '0, '0);
    send_item(rhh_pkg::ACT_INSERT, 64'h55, 4'd0, 64'd5, 32'hAAAA_5555);
    send_item(rhh_pkg::ACT_LOOKUP, 64'h99, 4'd0, 64'd5, '0);
    send_item(rhh_pkg::ACT_INSERT, '1, 4'd15, 64'd6, 32'h5555_AAAA);
    send_item(rhh_pkg::ACT_LOOKUP, '1, 4'd15, 64'd6, '0);
    send_item(rhh_pkg::ACT_NONE, '1, 4'd8, '1, '1);
    for (int i = 0; i < 4; i++)
      send_item(rhh_pkg::ACT_INSERT, 64'(i + 10), 4'd2, 64'h3FE, 32'(i));
    send_item(rhh_pkg::ACT_INSERT, 64'd20, 4'd2, 64'h3FF, 32'd20);
    send_item(rhh_pkg::ACT_INSERT, 64'd21, 4'd2, 64'h000, 32'd21);
    send_item(rhh_pkg::ACT_ERASE, 64'd11, 4'd2, 64'h3FE, '0);
    send_item(rhh_pkg::ACT_LOOKUP, 64'd13, 4'd2, 64'h3FE, '0);
    send_item(rhh_pkg::ACT_LOOKUP, 64'd21, 4'd2, 64'h000, '0);
    send_item(rhh_pkg::ACT_ERASE, 64'd11, 4'd2, 64'h3FE, '0);
    send_item(rhh_pkg::ACT_ERASE, '1, 4'd8, '1, '0);
    send_item(rhh_pkg::ACT_LOOKUP, '1, 4'd8, '1, '0);

    // Random phases across fill limits, the extremes among them.
    for (int ph = 0; ph <= 6; ph++) begin
      if (ph > 0) write_fill(fill_steps[ph-1]);
      repeat (225) random_item();
    end

    start_i = 1'b0;
    while (pending != 0 || busy_o) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    $display("Sent %0d items, checked %0d results, %0d refused as full.",
             sent, checked, refused);
    $display("Fill limits 85, 1, 0, 100, 127, 50 and 85 were applied in turn.");
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
